[design/twbd_pkg.sv]
package twbd_pkg;

  localparam int WORD_W      = 9;
  localparam int CHAR_W      = 8;
  localparam int VERT_W      = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int GLYPHS      = 96;
  localparam int GLYPH_IDX_W = $clog2(GLYPHS);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_ASCII_MODE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAR_MICROSPACES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_MICROLINES  = 2'd2;

  localparam logic [WORD_W-1:0] CMD_START = 9'h121;
  localparam logic [WORD_W-1:0] CMD_GLYPH = 9'h003;
  localparam logic [WORD_W-1:0] CMD_ERASE = 9'h004;
  localparam logic [WORD_W-1:0] CMD_VERT  = 9'h005;
  localparam logic [WORD_W-1:0] CMD_HORIZ = 9'h006;
  localparam int                RIGHT_BIT = 7;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;

  localparam logic               RST_ASCII_MODE       = 1'b1;
  localparam logic [CHAR_W-1:0]  RST_CHAR_MICROSPACES = 8'd10;
  localparam logic [VERT_W-1:0]  RST_LINE_MICROLINES  = 5'd16;

  localparam logic [CHAR_W-1:0] GLYPH_MAP [GLYPHS] = '{
    8'h61, 8'h6E, 8'h72, 8'h6D, 8'h63, 8'h73, 8'h64, 8'h68,
    8'h6C, 8'h66, 8'h6B, 8'h2C, 8'h56, 8'h2D, 8'h47, 8'h55,
    8'h46, 8'h42, 8'h5A, 8'h48, 8'h50, 8'h29, 8'h52, 8'h4C,
    8'h53, 8'h4E, 8'h43, 8'h54, 8'h44, 8'h45, 8'h49, 8'h41,
    8'h4A, 8'h4F, 8'h28, 8'h4D, 8'h2E, 8'h59, 8'h2C, 8'h2F,
    8'h57, 8'h39, 8'h4B, 8'h33, 8'h58, 8'h31, 8'h32, 8'h30,
    8'h35, 8'h34, 8'h36, 8'h38, 8'h37, 8'h2A, 8'h24, 8'h23,
    8'h25, 8'hA2, 8'h2B, 8'hB1, 8'h40, 8'h51, 8'h26, 8'h5B,
    8'h5D, 8'hB2, 8'hB3, 8'hBA, 8'hA7, 8'hB6, 8'hBD, 8'hBC,
    8'h21, 8'h3F, 8'h22, 8'h60, 8'h3D, 8'h3A, 8'h5F, 8'h3B,
    8'h78, 8'h71, 8'h76, 8'h7A, 8'h77, 8'h6A, 8'h2E, 8'h79,
    8'h62, 8'h67, 8'h75, 8'h70, 8'h69, 8'h74, 8'h6F, 8'h65
  };

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_CMD   = 3'd1,
    ST_GLYPH = 3'd2,
    ST_HDIR  = 3'd3,
    ST_RIGHT = 3'd4,
    ST_LEFT  = 3'd5,
    ST_VERT  = 3'd6
  } parse_state_t;

  // one decoded job; pair adds a trailing backspace beat
  typedef struct packed {
    logic              kind;
    logic [CHAR_W-1:0] char_code;
    logic [WORD_W-1:0] raw_word;
    logic              command_start;
    logic              pair;
  } job_t;

endpackage

[design/twbd_in_if.sv]
interface twbd_in_if;
  logic                        valid;
  logic                        ready;
  logic [twbd_pkg::WORD_W-1:0] bus_word;

  modport source (output valid, output bus_word, input ready);
  modport sink   (input valid, input bus_word, output ready);
endinterface

[design/twbd_out_if.sv]
interface twbd_out_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [twbd_pkg::CHAR_W-1:0] char_code;
  logic [twbd_pkg::WORD_W-1:0] raw_word;
  logic                        command_start;
  logic                        last;

  modport source (output valid, output kind, output char_code, output raw_word,
                  output command_start, output last, input ready);
  modport sink   (input valid, input kind, input char_code, input raw_word,
                  input command_start, input last, output ready);
endinterface

[design/twbd_cfg_if.sv]
interface twbd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [twbd_pkg::CFG_IDX_W-1:0]  index;
  logic [twbd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[design/typewriter_bus_word_decoder.sv]
// A result beat passes from its accepted bus word through the job queue and then the output register to out_ch.
// Throughput: one bus word per cycle while the job queue is not full; the output register sends one beat
// per cycle while out_ch is ready, so an erase, which gives two beats, holds the output for both of them.
// A two-entry job queue between parser and output lets either side stall alone.
// Reset (rst_n low, synchronous): parser idle, queue empty, no output beat,
// registers back to ASCII mode, 10 microspaces per character, 16 microlines per line.
module typewriter_bus_word_decoder (
  input  logic       clk,
  input  logic       rst_n,
  twbd_in_if.sink    in_ch,
  twbd_cfg_if.sink   cfg_ch,
  twbd_out_if.source out_ch
);

  logic           push;
  twbd_pkg::job_t push_job;
  logic           q_full;
  logic           pop;
  logic           head_valid;
  twbd_pkg::job_t head;

  twbd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  twbd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  twbd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

[design/twbd_front.sv]
module twbd_front (
  input  logic           clk,
  input  logic           rst_n,
  twbd_in_if.sink        in_ch,
  twbd_cfg_if.sink       cfg_ch,
  input  logic           q_full,
  output logic           push,
  output twbd_pkg::job_t push_job
);

  logic                                ascii_mode_r;
  logic [twbd_pkg::CHAR_W-1:0]         char_microspaces_r;
  logic [twbd_pkg::VERT_W-1:0]         line_microlines_r;
  twbd_pkg::parse_state_t              state_r;
  twbd_pkg::parse_state_t              state_nxt;
  logic                                acc;
  logic                                emit;
  logic [twbd_pkg::WORD_W-1:0]         w;
  logic [twbd_pkg::GLYPH_IDX_W-1:0]    glyph_idx;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_full;
  assign acc          = in_ch.valid && in_ch.ready;
  assign w            = in_ch.bus_word;
  assign glyph_idx    = w[twbd_pkg::GLYPH_IDX_W-1:0] - twbd_pkg::GLYPH_IDX_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ascii_mode_r       <= twbd_pkg::RST_ASCII_MODE;
      char_microspaces_r <= twbd_pkg::RST_CHAR_MICROSPACES;
      line_microlines_r  <= twbd_pkg::RST_LINE_MICROLINES;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        twbd_pkg::CFG_ASCII_MODE:       ascii_mode_r       <= cfg_ch.data[0];
        twbd_pkg::CFG_CHAR_MICROSPACES: char_microspaces_r <= cfg_ch.data;
        twbd_pkg::CFG_LINE_MICROLINES:
          line_microlines_r <= cfg_ch.data[twbd_pkg::VERT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= twbd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (acc && ascii_mode_r) begin
      case (state_r)
        twbd_pkg::ST_CMD: begin
          if (w == twbd_pkg::CMD_GLYPH)      state_nxt = twbd_pkg::ST_GLYPH;
          else if (w == twbd_pkg::CMD_VERT)  state_nxt = twbd_pkg::ST_VERT;
          else if (w == twbd_pkg::CMD_HORIZ) state_nxt = twbd_pkg::ST_HDIR;
          else                               state_nxt = twbd_pkg::ST_IDLE;
        end
        twbd_pkg::ST_HDIR: begin
          state_nxt = w[twbd_pkg::RIGHT_BIT] ? twbd_pkg::ST_RIGHT : twbd_pkg::ST_LEFT;
        end
        twbd_pkg::ST_GLYPH, twbd_pkg::ST_RIGHT, twbd_pkg::ST_LEFT,
        twbd_pkg::ST_VERT: begin
          state_nxt = twbd_pkg::ST_IDLE;
        end
        default: begin
          state_nxt = (w == twbd_pkg::CMD_START) ? twbd_pkg::ST_CMD : twbd_pkg::ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    emit     = 1'b0;
    push_job = '0;
    if (!ascii_mode_r) begin
      emit                   = 1'b1;
      push_job.kind          = 1'b1;
      push_job.raw_word      = w;
      push_job.command_start = (w == twbd_pkg::CMD_START);
    end else begin
      case (state_r)
        twbd_pkg::ST_CMD: begin
          if (w == twbd_pkg::CMD_ERASE) begin
            emit               = 1'b1;
            push_job.char_code = twbd_pkg::CH_SPACE;
            push_job.pair      = 1'b1;
          end
        end
        twbd_pkg::ST_GLYPH: begin
          if (w == '0) begin
            emit               = 1'b1;
            push_job.char_code = twbd_pkg::CH_SPACE;
          end else if (w <= twbd_pkg::WORD_W'(twbd_pkg::GLYPHS)) begin
            emit               = 1'b1;
            push_job.char_code = twbd_pkg::GLYPH_MAP[glyph_idx];
          end
        end
        twbd_pkg::ST_RIGHT: begin
          emit               = 1'b1;
          push_job.char_code = (w > {1'b0, char_microspaces_r}) ? twbd_pkg::CH_TAB
                                                                : twbd_pkg::CH_SPACE;
        end
        twbd_pkg::ST_LEFT: begin
          if (w == {1'b0, char_microspaces_r}) begin
            emit               = 1'b1;
            push_job.char_code = twbd_pkg::CH_BS;
          end
        end
        twbd_pkg::ST_VERT: begin
          if (w[twbd_pkg::VERT_W-1:0] == line_microlines_r) begin
            emit               = 1'b1;
            push_job.char_code = twbd_pkg::CH_CR;
          end
        end
        default: ;
      endcase
    end
  end

  assign push = acc && emit;

endmodule

[design/twbd_queue.sv]
module twbd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  twbd_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output twbd_pkg::job_t head
);

  twbd_pkg::job_t                mem_r [twbd_pkg::QUEUE_DEPTH];
  logic [twbd_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [twbd_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [twbd_pkg::QCNT_W-1:0]   count_r;
  logic [twbd_pkg::QCNT_W-1:0]   count_nxt;

  assign full       = (count_r == twbd_pkg::QCNT_W'(twbd_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop)      count_nxt = count_r + twbd_pkg::QCNT_W'(1);
    else if (pop && !push) count_nxt = count_r - twbd_pkg::QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + twbd_pkg::QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + twbd_pkg::QPTR_W'(1);
    end
  end

endmodule

[design/twbd_back.sv]
module twbd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  twbd_pkg::job_t head,
  output logic           pop,
  twbd_out_if.source     out_ch
);

  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic                        kind_r;
  logic                        kind_nxt;
  logic [twbd_pkg::CHAR_W-1:0] char_code_r;
  logic [twbd_pkg::CHAR_W-1:0] char_code_nxt;
  logic [twbd_pkg::WORD_W-1:0] raw_word_r;
  logic [twbd_pkg::WORD_W-1:0] raw_word_nxt;
  logic                        command_start_r;
  logic                        command_start_nxt;
  logic                        last_r;
  logic                        last_nxt;
  logic                        pending_r;
  logic                        pending_nxt;
  logic                        load;

  assign load = !out_valid_r || out_ch.ready;
  assign pop  = load && !pending_r && head_valid;

  always_comb begin
    out_valid_nxt     = out_valid_r;
    pending_nxt       = pending_r;
    kind_nxt          = kind_r;
    char_code_nxt     = char_code_r;
    raw_word_nxt      = raw_word_r;
    command_start_nxt = command_start_r;
    last_nxt          = last_r;
    if (load) begin
      if (pending_r) begin
        // second beat of an erase
        out_valid_nxt     = 1'b1;
        pending_nxt       = 1'b0;
        kind_nxt          = 1'b0;
        char_code_nxt     = twbd_pkg::CH_BS;
        raw_word_nxt      = '0;
        command_start_nxt = 1'b0;
        last_nxt          = 1'b1;
      end else if (head_valid) begin
        out_valid_nxt     = 1'b1;
        pending_nxt       = head.pair;
        kind_nxt          = head.kind;
        char_code_nxt     = head.char_code;
        raw_word_nxt      = head.raw_word;
        command_start_nxt = head.command_start;
        last_nxt          = !head.pair;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pending_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pending_r   <= pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r          <= kind_nxt;
    char_code_r     <= char_code_nxt;
    raw_word_r      <= raw_word_nxt;
    command_start_r <= command_start_nxt;
    last_r          <= last_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = kind_r;
  assign out_ch.char_code     = char_code_r;
  assign out_ch.raw_word      = raw_word_r;
  assign out_ch.command_start = command_start_r;
  assign out_ch.last          = last_r;

`ifndef SYNTH
  a_pending_has_beat: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> out_valid_r)
    else $error("pending backspace without a beat on the output");

  a_not_last_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !last_r) |-> pending_r)
    else $error("non-final beat without a following backspace");

  a_bs_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r && out_ch.ready) |=> (out_valid_r && last_r && char_code_r == twbd_pkg::CH_BS))
    else $error("erase pair not completed by a backspace");

  a_no_pop_pending: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !pending_r)
    else $error("queue popped while a backspace is pending");
`endif

endmodule

[tb/sv/twbd_checker.sv]
`timescale 1ns / 1ps

module twbd_checker
  import twbd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [WORD_W-1:0]     in_word,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_kind,
  input  logic [CHAR_W-1:0]     out_char,
  input  logic [WORD_W-1:0]     out_raw,
  input  logic                  out_cmd_start,
  input  logic                  out_last,
  output int                    mismatches,
  output int                    beats_pending
);

  typedef struct packed {
    logic              kind;
    logic [CHAR_W-1:0] char_code;
    logic [WORD_W-1:0] raw_word;
    logic              command_start;
    logic              last;
  } beat_t;

  localparam logic [CHAR_W-1:0] WHEEL_CHARS [GLYPHS] = '{
    8'h61, 8'h6E, 8'h72, 8'h6D, 8'h63, 8'h73, 8'h64, 8'h68,
    8'h6C, 8'h66, 8'h6B, 8'h2C, 8'h56, 8'h2D, 8'h47, 8'h55,
    8'h46, 8'h42, 8'h5A, 8'h48, 8'h50, 8'h29, 8'h52, 8'h4C,
    8'h53, 8'h4E, 8'h43, 8'h54, 8'h44, 8'h45, 8'h49, 8'h41,
    8'h4A, 8'h4F, 8'h28, 8'h4D, 8'h2E, 8'h59, 8'h2C, 8'h2F,
    8'h57, 8'h39, 8'h4B, 8'h33, 8'h58, 8'h31, 8'h32, 8'h30,
    8'h35, 8'h34, 8'h36, 8'h38, 8'h37, 8'h2A, 8'h24, 8'h23,
    8'h25, 8'hA2, 8'h2B, 8'hB1, 8'h40, 8'h51, 8'h26, 8'h5B,
    8'h5D, 8'hB2, 8'hB3, 8'hBA, 8'hA7, 8'hB6, 8'hBD, 8'hBC,
    8'h21, 8'h3F, 8'h22, 8'h60, 8'h3D, 8'h3A, 8'h5F, 8'h3B,
    8'h78, 8'h71, 8'h76, 8'h7A, 8'h77, 8'h6A, 8'h2E, 8'h79,
    8'h62, 8'h67, 8'h75, 8'h70, 8'h69, 8'h74, 8'h6F, 8'h65
  };

  beat_t             chars_due[$];
  logic              mode_ascii;
  logic [CHAR_W-1:0] microspaces;
  logic [VERT_W-1:0] microlines;
  parse_state_t      parser;
  int                err_count;

  function automatic void push_char(input logic [CHAR_W-1:0] ch, input logic fin);
    beat_t b;
    b           = '0;
    b.char_code = ch;
    b.last      = fin;
    chars_due.push_back(b);
  endfunction

  function automatic void predict_chars(input logic [WORD_W-1:0] w);
    beat_t b;
    if (!mode_ascii) begin
      b               = '0;
      b.kind          = 1'b1;
      b.raw_word      = w;
      b.command_start = (w == CMD_START);
      b.last          = 1'b1;
      chars_due.push_back(b);
    end else begin
      case (parser)
        ST_CMD: begin
          if (w == CMD_GLYPH) begin
            parser = ST_GLYPH;
          end else if (w == CMD_ERASE) begin
            push_char(CH_SPACE, 1'b0);
            push_char(CH_BS, 1'b1);
            parser = ST_IDLE;
          end else if (w == CMD_VERT) begin
            parser = ST_VERT;
          end else if (w == CMD_HORIZ) begin
            parser = ST_HDIR;
          end else begin
            parser = ST_IDLE;
          end
        end
        ST_GLYPH: begin
          if (w == '0) push_char(CH_SPACE, 1'b1);
          else if (w <= GLYPHS) push_char(WHEEL_CHARS[w - 1], 1'b1);
          parser = ST_IDLE;
        end
        ST_HDIR: parser = w[RIGHT_BIT] ? ST_RIGHT : ST_LEFT;
        ST_RIGHT: begin
          push_char((w > {1'b0, microspaces}) ? CH_TAB : CH_SPACE, 1'b1);
          parser = ST_IDLE;
        end
        ST_LEFT: begin
          if (w == {1'b0, microspaces}) push_char(CH_BS, 1'b1);
          parser = ST_IDLE;
        end
        ST_VERT: begin
          if (w[VERT_W-1:0] == microlines) push_char(CH_CR, 1'b1);
          parser = ST_IDLE;
        end
        default: parser = (w == CMD_START) ? ST_CMD : ST_IDLE;
      endcase
    end
  endfunction

  always @(posedge clk) begin
    beat_t got;
    beat_t exp_beat;
    if (!rst_n) begin
      chars_due.delete();
      mode_ascii  = RST_ASCII_MODE;
      microspaces = RST_CHAR_MICROSPACES;
      microlines  = RST_LINE_MICROLINES;
      parser      = ST_IDLE;
      err_count   = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_kind, out_char, out_raw, out_cmd_start, out_last};
        if (chars_due.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: unexpected beat kind=%0d char=%h raw=%h start=%0d last=%0d",
                     $realtime, got.kind, got.char_code, got.raw_word,
                     got.command_start, got.last);
        end else begin
          exp_beat = chars_due.pop_front();
          if (got.kind != exp_beat.kind || got.char_code != exp_beat.char_code ||
              got.raw_word != exp_beat.raw_word ||
              got.command_start != exp_beat.command_start || got.last != exp_beat.last) begin
            err_count++;
            if (err_count <= 10)
              $display({"%0t: beat mismatch exp kind=%0d char=%h raw=%h start=%0d last=%0d",
                        " got kind=%0d char=%h raw=%h start=%0d last=%0d"},
                       $realtime, exp_beat.kind, exp_beat.char_code, exp_beat.raw_word,
                       exp_beat.command_start, exp_beat.last, got.kind, got.char_code,
                       got.raw_word, got.command_start, got.last);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ASCII_MODE:       mode_ascii  = cfg_data[0];
          CFG_CHAR_MICROSPACES: microspaces = cfg_data;
          CFG_LINE_MICROLINES:  microlines  = cfg_data[VERT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_chars(in_word);
    end
    mismatches    <= err_count;
    beats_pending <= chars_due.size();
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import twbd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic clk;
  logic rst_n;
  logic quiet;
  int   mismatches;
  int   beats_pending;
  int   words_sent;
  logic [CHAR_W-1:0] cur_microspaces;
  logic [VERT_W-1:0] cur_microlines;

  twbd_in_if  in_ch ();
  twbd_cfg_if cfg_ch ();
  twbd_out_if out_ch ();

  typewriter_bus_word_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  twbd_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_word       (in_ch.bus_word),
    .cfg_valid     (cfg_ch.valid),
    .cfg_ready     (cfg_ch.ready),
    .cfg_index     (cfg_ch.index),
    .cfg_data      (cfg_ch.data),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_kind      (out_ch.kind),
    .out_char      (out_ch.char_code),
    .out_raw       (out_ch.raw_word),
    .out_cmd_start (out_ch.command_start),
    .out_last      (out_ch.last),
    .mismatches    (mismatches),
    .beats_pending (beats_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= quiet || ($urandom_range(99) >= 21);
    end
  end

  task automatic send_word(input logic [WORD_W-1:0] w);
    if (!quiet && $urandom_range(99) < 21) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 21);
    end
    in_ch.valid    <= 1'b1;
    in_ch.bus_word <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  // stop sending and let every pending char drain out
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (beats_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic mode, input logic [CHAR_W-1:0] ms,
                            input logic [VERT_W-1:0] ml);
    logic [CFG_DATA_W-1:0] d;
    drain();
    d    = CFG_DATA_W'($urandom_range(255));
    d[0] = mode;
    write_reg(CFG_ASCII_MODE, d);
    write_reg(CFG_CHAR_MICROSPACES, ms);
    d           = CFG_DATA_W'($urandom_range(255));
    d[VERT_W-1:0] = ml;
    write_reg(CFG_LINE_MICROLINES, d);
    cur_microspaces = ms;
    cur_microlines  = ml;
  endtask

  function automatic logic [WORD_W-1:0] near_amount();
    logic [WORD_W-1:0] base;
    base = {1'b0, cur_microspaces};
    case ($urandom_range(3))
      0: return base;
      1: return base + 9'd1;
      2: return base - 9'd1;
      default: return WORD_W'($urandom_range(511));
    endcase
  endfunction

  task automatic send_sequence();
    int pick;
    logic [WORD_W-1:0] w;
    pick = $urandom_range(99);
    if (pick < 10) begin
      send_word(WORD_W'($urandom_range(511)));
    end else begin
      send_word(CMD_START);
      pick = $urandom_range(99);
      if (pick < 30) begin
        send_word(CMD_GLYPH);
        if ($urandom_range(99) < 85) send_word(WORD_W'($urandom_range(GLYPHS)));
        else send_word(WORD_W'($urandom_range(511)));
      end else if (pick < 42) begin
        send_word(CMD_ERASE);
      end else if (pick < 60) begin
        send_word(CMD_VERT);
        w = WORD_W'($urandom_range(511));
        if ($urandom_range(99) < 70) w[VERT_W-1:0] = cur_microlines;
        send_word(w);
      end else if (pick < 90) begin
        send_word(CMD_HORIZ);
        send_word(WORD_W'($urandom_range(511)));
        send_word(near_amount());
      end else if (pick < 95) begin
        send_word(WORD_W'($urandom_range(511)));
      end
    end
  endtask

  initial begin
    int   phase_goal;
    logic paused;
    in_ch.valid     <= 1'b0;
    in_ch.bus_word  <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= '0;
    cfg_ch.data     <= '0;
    rst_n           <= 1'b0;
    quiet           = 1'b0;
    words_sent      = 0;
    cur_microspaces = RST_CHAR_MICROSPACES;
    cur_microlines  = RST_LINE_MICROLINES;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: glyph edges, erase, moves, carriage return, unknown command, then raw mode
    send_word(9'h000);
    send_word(CMD_START); send_word(CMD_GLYPH); send_word(9'd1);
    send_word(CMD_START); send_word(CMD_GLYPH); send_word(9'd0);
    send_word(CMD_START); send_word(CMD_GLYPH); send_word(9'd96);
    send_word(CMD_START); send_word(CMD_GLYPH); send_word(9'h1FF);
    send_word(CMD_START); send_word(CMD_ERASE);
    send_word(CMD_START); send_word(CMD_HORIZ); send_word(9'h080); send_word(9'h00B);
    send_word(CMD_START); send_word(CMD_HORIZ); send_word(9'h17F); send_word(9'h00A);
    send_word(CMD_START); send_word(CMD_VERT); send_word(9'h1F0);
    send_word(CMD_START); send_word(9'h1FF);
    set_config(1'b0, RST_CHAR_MICROSPACES, RST_LINE_MICROLINES);
    send_word(CMD_START); send_word(9'h1FF); send_word(9'h000);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_config(1'b1, 8'd0, 5'd0);
        1: set_config(1'b1, 8'd255, 5'd31);
        2: set_config(1'b0, CHAR_W'($urandom_range(255)), VERT_W'($urandom_range(31)));
        3: begin
          set_config(1'b1, CHAR_W'($urandom_range(30)), VERT_W'($urandom_range(31)));
          write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(255)));
        end
        4: set_config(1'b1, RST_CHAR_MICROSPACES, RST_LINE_MICROLINES);
        default: set_config(1'b1, CHAR_W'($urandom_range(255)), VERT_W'($urandom_range(31)));
      endcase
      quiet      = (phase == 4);
      paused     = 1'b0;
      phase_goal = words_sent + 300;
      while (words_sent < phase_goal) begin
        send_sequence();
        if (!paused && words_sent >= phase_goal - 150) begin
          drain();
          paused = 1'b1;
        end
      end
    end
    quiet = 1'b0;

    in_ch.valid <= 1'b0;
    for (int i = 0; i < 2000 && beats_pending != 0; i++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && beats_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
